FILE: rtl/board_bus_decoder_keypad_defines.svh
// ----------------------------------------------------------------------------
// board_bus_decoder_keypad_defines
// Assertion macros shared by the bus decoder RTL.
// ----------------------------------------------------------------------------
`ifndef BOARD_BUS_DECODER_KEYPAD_DEFINES_SVH
`define BOARD_BUS_DECODER_KEYPAD_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BBDK_ASSERT_IMP(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("bus decoder check failed");

// Next-cycle implication, disabled during reset.
`define BBDK_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("bus decoder check failed");

`endif

FILE: rtl/bbdk_pkg.sv
// ----------------------------------------------------------------------------
// bbdk_pkg
// Types, address map and keypad tables of the board bus decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bbdk_pkg;

  localparam int RAM_DEPTH_DEFAULT = 32768;
  localparam logic [16:0] KEY_HOLD_TICKS = 17'd100000;
  localparam logic [3:0] BOARD_MODE_RESET = 4'd2;

  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 48;
  localparam int APB_ADDR_W = 3;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_KEY   = 2'd2,
    REQ_TICK  = 2'd3
  } req_t;

  // Configuration register word index (paddr[2])
  localparam logic REG_BOARD_MODE = 1'b0;

  localparam logic [15:0] ADDR_METER   = 16'h8000;
  localparam logic [15:0] ADDR_KEYCOL  = 16'h8001;
  localparam logic [15:0] ADDR_RANGE   = 16'h9000;
  localparam logic [15:0] ADDR_DISPLAY = 16'h9001;
  localparam logic [15:0] ADDR_PORT_C  = 16'h9002;
  localparam logic [15:0] ADDR_PC_BIT  = 16'h9003;

  // Result item waiting for the RAM read data
  typedef struct packed {
    logic       from_ram;
    logic [7:0] rd_other;
    logic       ext_irq_ack;
    logic [7:0] range_value;
    logic [7:0] display_value;
    logic [7:0] port_c_value;
    logic [7:0] key_columns;
  } stage_t;

  // Active-low column mask for a held key; row A and row B enables.
  function automatic logic [7:0] key_columns_of(input logic [6:0] key,
                                                input logic row_a_en,
                                                input logic row_b_en);
    logic [7:0] cols;
    cols = 8'hFF;
    if (row_a_en) begin
      unique case (key)
        7'h37:   cols[7] = 1'b0;  // '7'
        7'h38:   cols[5] = 1'b0;  // '8'
        7'h39:   cols[3] = 1'b0;  // '9'
        7'h0A:   cols[1] = 1'b0;  // newline
        7'h34:   cols[6] = 1'b0;  // '4'
        7'h35:   cols[4] = 1'b0;  // '5'
        7'h36:   cols[2] = 1'b0;  // '6'
        7'h2F:   cols[0] = 1'b0;  // '/'
        default: cols = cols;
      endcase
    end
    if (row_b_en) begin
      unique case (key)
        7'h31:   cols[7] = 1'b0;  // '1'
        7'h32:   cols[5] = 1'b0;  // '2'
        7'h33:   cols[3] = 1'b0;  // '3'
        7'h6D:   cols[1] = 1'b0;  // 'm'
        7'h23:   cols[6] = 1'b0;  // '#'
        7'h30:   cols[4] = 1'b0;  // '0'
        7'h2C:   cols[2] = 1'b0;  // ','
        7'h2A:   cols[0] = 1'b0;  // '*'
        default: cols = cols;
      endcase
    end
    return cols;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/board_bus_decoder_keypad.sv
// ----------------------------------------------------------------------------
// board_bus_decoder_keypad
// External bus decoder, board registers and keypad column latch.
// ----------------------------------------------------------------------------
// One request item per cycle is taken on the slave stream while the master
// stream does not stall: a bus read, a bus write, a key press or a tick.
// Each item gives exactly one result item on the master stream, through the
// stage one register and the output register, with the read byte (0 for
// anything but a read), the interrupt acknowledge of a meter read and the
// register and column contents after the request. The single-port RAM has a
// registered read, and one result may wait at the output while the next item
// is taken. The RAM gets no clearing pass: an entry must be written before it
// is read. board_mode is written over the APB port at byte address 0.
`default_nettype none

`include "board_bus_decoder_keypad_defines.svh"

module board_bus_decoder_keypad #(
  parameter int RAM_DEPTH = bbdk_pkg::RAM_DEPTH_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // s_axis_tdata: bus_address[15:0], write_data[23:16], key_code[30:24],
  //               meter_data[38:31], zero pad[39]
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [bbdk_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // s_axis_tuser: req_type[1:0]
  input  wire logic [bbdk_pkg::IN_USER_W-1:0]  s_axis_tuser,
  // m_axis_tdata: read_data[7:0], ext_irq_ack[8], range_value[16:9],
  //               display_value[24:17], port_c_value[32:25],
  //               key_columns[40:33], zero pad[47:41]
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [bbdk_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [bbdk_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import bbdk_pkg::*;

  localparam int RAM_AW    = $clog2(RAM_DEPTH);
  // Restoring steps to fold a 15-bit address into the RAM depth
  localparam int MOD_STEPS = 16 - $clog2(RAM_DEPTH);

  // Unpack the request item
  req_t       req;
  logic [15:0] bus_address;
  logic [7:0]  write_data;
  logic [6:0]  key_code;
  logic [7:0]  meter_data;

  assign req         = req_t'(s_axis_tuser);
  assign bus_address = s_axis_tdata[15:0];
  assign write_data  = s_axis_tdata[23:16];
  assign key_code    = s_axis_tdata[30:24];
  assign meter_data  = s_axis_tdata[38:31];

  // Configuration
  logic [3:0] board_mode;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_BOARD_MODE) ? {28'd0, board_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      board_mode <= BOARD_MODE_RESET;
    end else if (cfg_write && paddr[2] == REG_BOARD_MODE) begin
      board_mode <= pwdata[3:0];
    end
  end

  // Handshake: stage one waits for RAM data, the output register holds the
  // finished result item.
  stage_t s1;
  logic   s1_valid;
  logic   s1_adv;
  logic   accept;
  logic [7:0] out_read_data;
  logic       out_ack;
  logic [7:0] out_range, out_display, out_port_c, out_cols;

  assign s1_adv        = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Board registers
  logic [7:0]  range_reg, display_reg, port_c_reg, column_latch;
  logic [6:0]  pending_key, held_key;
  logic [16:0] hold_count;
  logic [7:0]  range_reg_next, display_reg_next, port_c_reg_next, column_latch_next;
  logic [6:0]  pending_key_next, held_key_next;
  logic [16:0] hold_count_next;
  logic [7:0]  rd_other;
  logic        ack;
  logic        is_ram;
  logic [2:0]  pc_bit;

  assign is_ram = !bus_address[15];
  assign pc_bit = write_data[3:1];

  always_comb begin
    range_reg_next    = range_reg;
    display_reg_next  = display_reg;
    port_c_reg_next   = port_c_reg;
    column_latch_next = column_latch;
    pending_key_next  = pending_key;
    held_key_next     = held_key;
    hold_count_next   = hold_count;
    rd_other          = 8'd0;
    ack               = 1'b0;
    unique case (req)
      REQ_READ: begin
        priority if (is_ram) begin
          rd_other = 8'd0;
        end else if (bus_address == ADDR_METER) begin
          rd_other = meter_data;
          ack      = 1'b1;
        end else if (bus_address == ADDR_KEYCOL) begin
          rd_other = column_latch;
        end else if (bus_address == ADDR_RANGE) begin
          rd_other = range_reg;
        end else if (bus_address == ADDR_PORT_C) begin
          rd_other = {board_mode, port_c_reg[3:0]};
        end else begin
          rd_other = 8'hFF;
        end
      end
      REQ_WRITE: begin
        priority if (is_ram) begin
          range_reg_next = range_reg;
        end else if (bus_address == ADDR_RANGE) begin
          range_reg_next = write_data;
        end else if (bus_address == ADDR_DISPLAY) begin
          display_reg_next = write_data;
        end else if (bus_address == ADDR_PORT_C) begin
          port_c_reg_next = write_data;
        end else if (bus_address == ADDR_PC_BIT && !write_data[7]) begin
          // set or clear one port C bit
          port_c_reg_next[pc_bit] = write_data[0];
        end else begin
          range_reg_next = range_reg;
        end
      end
      REQ_KEY: begin
        pending_key_next = key_code;
      end
      REQ_TICK: begin
        // take a pending key, then count the hold down
        if (pending_key != 7'd0) begin
          held_key_next    = pending_key;
          hold_count_next  = KEY_HOLD_TICKS;
          pending_key_next = 7'd0;
        end
        if (hold_count_next != 17'd0) begin
          hold_count_next = hold_count_next - 17'd1;
        end else begin
          held_key_next = 7'd0;
        end
        column_latch_next = key_columns_of(held_key_next, !range_reg[7], !port_c_reg[3]);
      end
      default: rd_other = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      range_reg    <= 8'd0;
      display_reg  <= 8'd0;
      port_c_reg   <= 8'd0;
      column_latch <= 8'd0;
      pending_key  <= 7'd0;
      held_key     <= 7'd0;
      hold_count   <= 17'd0;
    end else if (accept) begin
      range_reg    <= range_reg_next;
      display_reg  <= display_reg_next;
      port_c_reg   <= port_c_reg_next;
      column_latch <= column_latch_next;
      pending_key  <= pending_key_next;
      held_key     <= held_key_next;
      hold_count   <= hold_count_next;
    end
  end

  // Fold the address into the RAM depth, one compare and subtract a step
  logic [23:0] ram_rem;
  logic [RAM_AW-1:0] ram_index;

  always_comb begin
    ram_rem = {9'd0, bus_address[14:0]};
    for (int k = MOD_STEPS - 1; k >= 0; k--) begin
      if (ram_rem >= (24'(RAM_DEPTH) << k)) begin
        ram_rem = ram_rem - (24'(RAM_DEPTH) << k);
      end
    end
  end

  assign ram_index = ram_rem[RAM_AW-1:0];

  // RAM: write at accept, registered read; hold the read data until the next
  // RAM read so a stalled stage one keeps its byte.
  logic [7:0] ext_ram [RAM_DEPTH];
  logic [7:0] ram_q;
  logic       ram_we, ram_re;

  assign ram_we = accept && req == REQ_WRITE && is_ram;
  assign ram_re = accept && req == REQ_READ && is_ram;

  always_ff @(posedge clk) begin
    if (ram_we) begin
      ext_ram[ram_index] <= write_data;
    end
    if (ram_re) begin
      ram_q <= ext_ram[ram_index];
    end
  end

  // Stage one
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept || (s1_valid && !s1_adv);
    end
    if (accept) begin
      s1.from_ram      <= (req == REQ_READ) && is_ram;
      s1.rd_other      <= rd_other;
      s1.ext_irq_ack   <= ack;
      s1.range_value   <= range_reg_next;
      s1.display_value <= display_reg_next;
      s1.port_c_value  <= port_c_reg_next;
      s1.key_columns   <= column_latch_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      m_axis_tvalid <= s1_adv || (m_axis_tvalid && !m_axis_tready);
    end
    if (s1_adv) begin
      out_read_data <= s1.from_ram ? ram_q : s1.rd_other;
      out_ack       <= s1.ext_irq_ack;
      out_range     <= s1.range_value;
      out_display   <= s1.display_value;
      out_port_c    <= s1.port_c_value;
      out_cols      <= s1.key_columns;
    end
  end

  assign m_axis_tdata = {7'd0, out_cols, out_port_c, out_display, out_range,
                         out_ack, out_read_data};

  // Checks
  `BBDK_ASSERT_IMP(a_stall_only_when_full, clk, rst,
    !s_axis_tready, s1_valid && m_axis_tvalid)
  `BBDK_ASSERT_IMP(a_ack_not_ram, clk, rst,
    s1_valid && s1.ext_irq_ack, !s1.from_ram)
  `BBDK_ASSERT_NEXT(a_display_load, clk, rst,
    accept && req == REQ_WRITE && bus_address == ADDR_DISPLAY,
    display_reg == $past(write_data))
  `BBDK_ASSERT_NEXT(a_tick_takes_key, clk, rst,
    accept && req == REQ_TICK && pending_key != 7'd0,
    held_key == $past(pending_key) && pending_key == 7'd0)

endmodule

`default_nettype wire
